>>> hdl/nsv_pkg.sv
package nsv_pkg;

    localparam int OUT_W = 13;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // what a transaction needs after acceptance
    localparam logic [1:0] K_IMMED = 2'd0;
    localparam logic [1:0] K_EMPTY = 2'd1;
    localparam logic [1:0] K_WALK  = 2'd2;
    localparam logic [1:0] K_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [11:0] index;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] prev_index;
        logic [OUT_W-1:0] next_index;
        logic [OUT_W-1:0] count;
    } t_out;

    typedef struct packed {
        logic latch;
        logic walk;
        logic finish;
        logic rd_done;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
    } t_dp_sts;

endpackage

>>> hdl/nsv_ram.sv
module nsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/nsv_ctrl.sv
module nsv_ctrl import nsv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_FINISH = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       slot_free;

    assign slot_free = !r_ovalid || !i_out_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_sts.kind)
                        K_WALK:  n_state = S_WALK;
                        K_EMPTY: n_state = S_FINISH;
                        K_READ:  n_state = S_READ;
                        default: n_state = S_PUSH;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_PUSH;
            end
            S_READ: begin
                o_cmd.rd_done = 1'b1;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                if (slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

>>> hdl/nsv_datapath.sv
module nsv_datapath import nsv_pkg::*; #(
    parameter int DEPTH      = 4096,
    parameter int VALUE_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_out    o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] NONE = CW'(DEPTH);

    function automatic logic [OUT_W-1:0] to_out(input logic [31:0] v);
        to_out = v[OUT_W-1:0];
    endfunction

    logic                  r_mode;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_top;
    logic [VALUE_BITS-1:0] r_val;
    t_out                  r_res;
    t_out                  r_out;

    logic [63:0]           val_ext;
    logic [VALUE_BITS-1:0] val_in;
    logic [31:0]           idx_ext;
    logic                  full;
    logic                  idx_ok;
    logic [CW-1:0]         pos_m1;
    logic [CW-1:0]         count_inc;
    logic [CW-1:0]         top_norm;
    logic [VALUE_BITS-1:0] val_rd;
    logic [CW-1:0]         prev_rd;
    logic [CW-1:0]         next_rd;
    logic                  beat;
    logic                  top_end;
    logic                  re;
    logic [AW-1:0]         rd_addr;
    logic                  next_we;
    logic [AW-1:0]         next_waddr;
    logic [CW-1:0]         next_wdata;
    t_out                  imm_res;
    t_out                  fin_res;
    t_out                  rd_res;

    assign val_ext   = 64'(i_in.value);
    assign val_in    = val_ext[VALUE_BITS-1:0];
    assign idx_ext   = 32'(i_in.index);
    assign full      = (r_count == NONE);
    assign idx_ok    = (idx_ext < 32'(r_count)) && (idx_ext < 32'(DEPTH));
    assign pos_m1    = r_count - CW'(1);
    assign count_inc = r_count + CW'(1);
    assign top_norm  = (r_top >= r_count) ? NONE : r_top;

    assign beat    = r_mode ? (val_rd < r_val) : (val_rd > r_val);
    assign top_end = (prev_rd >= r_count);

    always_comb begin
        o_sts.last = !beat || top_end;
        case (i_in.command)
            CMD_APPEND: begin
                if (full) begin
                    o_sts.kind = K_IMMED;
                end else if (r_count == '0) begin
                    o_sts.kind = K_EMPTY;
                end else begin
                    o_sts.kind = K_WALK;
                end
            end
            CMD_READ: begin
                o_sts.kind = idx_ok ? K_READ : K_IMMED;
            end
            default: begin
                o_sts.kind = K_IMMED;
            end
        endcase
    end

    // one read address serves the value and both link stores
    always_comb begin
        if (i_cmd.latch) begin
            rd_addr = (i_in.command == CMD_READ) ? idx_ext[AW-1:0] : pos_m1[AW-1:0];
        end else begin
            rd_addr = prev_rd[AW-1:0];
        end
    end
    assign re = i_cmd.latch || (i_cmd.walk && beat && !top_end);

    assign next_we    = i_cmd.finish || (i_cmd.walk && beat);
    assign next_waddr = i_cmd.finish ? r_count[AW-1:0] : r_top[AW-1:0];
    assign next_wdata = i_cmd.finish ? NONE : r_count;

    nsv_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_val),
        .i_re    (re),
        .i_raddr (rd_addr),
        .o_rdata (val_rd)
    );

    nsv_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (top_norm),
        .i_re    (re),
        .i_raddr (rd_addr),
        .o_rdata (prev_rd)
    );

    nsv_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (re),
        .i_raddr (rd_addr),
        .o_rdata (next_rd)
    );

    always_comb begin
        imm_res = '0;
        case (i_in.command)
            CMD_APPEND: begin
                imm_res.status     = ST_FULL;
                imm_res.prev_index = to_out(32'(r_count));
                imm_res.next_index = to_out(32'(r_count));
                imm_res.count      = to_out(32'(r_count));
            end
            CMD_READ: begin
                imm_res.status     = ST_RANGE;
                imm_res.prev_index = to_out(32'(r_count));
                imm_res.next_index = to_out(32'(r_count));
                imm_res.count      = to_out(32'(r_count));
            end
            CMD_CLEAR: begin
                imm_res = '0;
            end
            default: begin
                imm_res.count = to_out(32'(r_count));
            end
        endcase
    end

    always_comb begin
        fin_res.status     = ST_OK;
        fin_res.prev_index = to_out(32'((top_norm == NONE) ? count_inc : top_norm));
        fin_res.next_index = to_out(32'(count_inc));
        fin_res.count      = to_out(32'(count_inc));

        rd_res.status      = ST_OK;
        rd_res.prev_index  = to_out(32'((prev_rd >= NONE) ? r_count : prev_rd));
        rd_res.next_index  = to_out(32'((next_rd >= NONE) ? r_count : next_rd));
        rd_res.count       = to_out(32'(r_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.latch && i_in.command == CMD_CLEAR) begin
                r_count <= '0;
            end
            if (i_cmd.finish) begin
                r_count <= count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_val <= val_in;
            r_top <= (r_count == '0) ? NONE : pos_m1;
            r_res <= imm_res;
        end
        if (i_cmd.walk && beat) begin
            r_top <= prev_rd;
        end
        if (i_cmd.finish) begin
            r_res <= fin_res;
        end
        if (i_cmd.rd_done) begin
            r_res <= rd_res;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_out = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NONE)
        else $error("fill count above capacity");

    a_walk_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_top < r_count))
        else $error("stack walk reached an entry not yet appended");

    a_finish_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == $past(count_inc)))
        else $error("append did not advance fill count");
`endif

endmodule

>>> hdl/nearest_smaller_values_engine_top.sv
// All nearest smaller (mode 0) or greater (mode 1) values over an appended sequence of up to
// DEPTH entries. Commands: append a value, read the previous/next links of an index, clear.
// A missing link reads as the current count. Each transaction is handled alone: an append
// walks the stack, popping each entry that the new value beats, and stops at a surviving
// entry or when the stack empties (no walk when the sequence is empty); the walk visits one
// entry per cycle through the single read port of the value and link memories. A finished
// result waits in the output register, so the next transaction is accepted while it is
// stalled. The mode register is written through the configuration channel, which is always
// ready.
module nearest_smaller_values_engine_top import nsv_pkg::*; #(
    parameter int DEPTH      = 4096,
    parameter int VALUE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    nsv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    nsv_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out      (o_out)
    );

endmodule
